FILE: sv/assert_macros.svh
// Assertion helpers used by the chunk list allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg
// Codes shared by the chunk list allocator: operations, register indexes and
// ordering policies.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_POOL  = 1'b1;

    localparam logic [1:0] POL_ADDR     = 2'd0;
    localparam logic [1:0] POL_ASC      = 2'd1;
    localparam logic [1:0] POL_DESC     = 2'd2;
    localparam logic [1:0] POL_DESC_ALT = 2'd3;

endpackage

FILE: sv/cla_ram.sv
// ----------------------------------------------------------------------------
// cla_ram
// Chunk record memory: start, length, used mark and link per slot, one read
// and one write port, registered read data. Slot 0 reads as the initial
// whole-pool chunk until it is first written after a rebuild.
// ----------------------------------------------------------------------------
module cla_ram #(
    parameter int IW = 5,
    parameter int OB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          init,
    input  logic [OB:0]   init_len,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [OB-1:0] rd_start,
    output logic [OB:0]   rd_len,
    output logic          rd_used,
    output logic [IW-1:0] rd_link,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [OB-1:0] wr_start,
    input  logic [OB:0]   wr_len,
    input  logic          wr_used,
    input  logic [IW-1:0] wr_link
);

    localparam int RW = OB + OB + 1 + 1 + IW;
    localparam int DEPTH = 1 << IW;

    logic [RW-1:0] mem [DEPTH];
    logic [RW-1:0] q_reg;
    logic          fresh0_reg;
    logic          zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_len, wr_used, wr_link};
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh0_reg <= 1'b1;
            zero_reg   <= 1'b0;
        end
        else
        begin
            if (init)
            begin
                fresh0_reg <= 1'b1;
            end
            else if (wr_en && wr_addr == '0)
            begin
                fresh0_reg <= 1'b0;
            end
            if (rd_en)
            begin
                zero_reg <= fresh0_reg && rd_addr == '0;
            end
        end
    end

    assign rd_start = zero_reg ? '0 : q_reg[RW-1 -: OB];
    assign rd_len   = zero_reg ? init_len : q_reg[IW+1 +: OB+1];
    assign rd_used  = zero_reg ? 1'b0 : q_reg[IW];
    assign rd_link  = zero_reg ? '0 : q_reg[IW-1:0];

endmodule

FILE: sv/cla_slots.sv
// ----------------------------------------------------------------------------
// cla_slots
// Spare slot pool: a stack of slots released by merging, backed by a count of
// slots never used since the last rebuild. A slot taken is returned from registers.
// ----------------------------------------------------------------------------
module cla_slots #(
    parameter int DEPTH = 32,
    parameter int IW = 5,
    parameter int CW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          push,
    input  logic [IW-1:0] push_slot,
    input  logic          take,
    output logic [IW-1:0] slot
);

    logic [IW-1:0] stack [DEPTH];
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] sp_dec;
    logic          from_stack_reg;
    logic [IW-1:0] fresh_out_reg;
    logic [IW-1:0] rd_reg;

    assign sp_dec = sp_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack[sp_reg[IW-1:0]] <= push_slot;
        end
        if (take && sp_reg != '0)
        begin
            rd_reg <= stack[sp_dec[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            fresh_reg      <= CW'(1);
            from_stack_reg <= 1'b0;
            fresh_out_reg  <= '0;
        end
        else if (clear)
        begin
            sp_reg    <= '0;
            fresh_reg <= CW'(1);
        end
        else
        begin
            if (push)
            begin
                sp_reg <= sp_reg + CW'(1);
            end
            else if (take)
            begin
                if (sp_reg != '0)
                begin
                    sp_reg         <= sp_dec;
                    from_stack_reg <= 1'b1;
                end
                else
                begin
                    fresh_reg      <= fresh_reg + CW'(1);
                    fresh_out_reg  <= fresh_reg[IW-1:0];
                    from_stack_reg <= 1'b0;
                end
            end
        end
    end

    assign slot = from_stack_reg ? rd_reg : fresh_out_reg;

endmodule

FILE: sv/chunk_list_allocator.sv
// Allocate: the first-fit walk reads and then evaluates each chunk in turn; an exact fit
// writes in the evaluate step, a split in address order adds a write of the used part and
// one of the remainder; size-ordered policies unlink the chunk and add two insertion walks.
// Release: the walk reads and then evaluates each chunk up to the match;
// address order adds a merge pass over the list.
// One request at a time; done pulses for one cycle and cannot be held off.
// Reset gives one free chunk covering the whole pool, address order policy.
// ----------------------------------------------------------------------------
// chunk_list_allocator
// First-fit chunk list allocator with splitting, size-ordered reinsertion and
// merging of adjacent free chunks, held in a linked record memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chunk_list_allocator
    import cla_pkg::*;
#(
    parameter int MAX_CHUNKS = 32,
    parameter int OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [OFFSET_BITS:0]   request_bytes,
    input  logic [OFFSET_BITS-1:0] release_offset,
    output logic                   done,
    output logic [OFFSET_BITS-1:0] granted_offset,
    output logic                   success,
    output logic [OFFSET_BITS:0]   free_total,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [OFFSET_BITS:0]   cfg_data
);

    localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int OB = OFFSET_BITS;
    localparam int LW = OFFSET_BITS + 1;
    localparam logic [LW-1:0] POOL_MAX = LW'(1) << OFFSET_BITS;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CHUNKS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_A_RD, ST_A_EV, ST_A_SLOT, ST_A_WRS,
        ST_I_BEGIN, ST_I_RD, ST_I_EV, ST_I_INS, ST_I_LNK,
        ST_R_RD, ST_R_EV,
        ST_M_BEGIN, ST_M_P, ST_M_Q, ST_M_QEV, ST_M_END
    } state_t;

    state_t        state_reg;
    logic          done_reg;
    logic          res_ok_reg;
    logic [OB-1:0] res_off_reg;
    logic [1:0]    policy_reg;
    logic [LW-1:0] pool_reg;
    logic [LW-1:0] free_reg;
    logic [IW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    logic [LW-1:0] bytes_reg;
    logic [OB-1:0] off_reg;
    logic [IW-1:0] cur_reg;
    logic [CW-1:0] i_reg;
    logic          prev_v_reg;
    logic [IW-1:0] prev_slot_reg;
    logic [OB-1:0] prev_start_reg;
    logic [LW-1:0] prev_len_reg;
    logic          prev_used_reg;
    logic [IW-1:0] prev_link_reg;
    logic          dirty_reg;
    logic [IW-1:0] c_slot_reg;
    logic [OB-1:0] c_start_reg;
    logic [IW-1:0] c_link_reg;
    logic [IW-1:0] s_slot_reg;
    logic [LW-1:0] rem_reg;
    logic          phase_reg;
    logic [LW-1:0] ins_len_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [OB-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic          rd_used;
    logic [IW-1:0] rd_link;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [OB-1:0] wr_start;
    logic [LW-1:0] wr_len;
    logic          wr_used;
    logic [IW-1:0] wr_link;
    logic          ram_init;
    logic          slot_take;
    logic          slot_push;
    logic [IW-1:0] slot;

    logic          fits;
    logic [LW-1:0] rem_w;
    logic          stop;
    logic          merge_ok;
    logic [IW-1:0] x_slot;
    logic [OB-1:0] x_start;
    logic [LW-1:0] x_len;
    logic [LW-1:0] cfg_pool;
    logic [OB-1:0] split_start;

    assign ram_init = (state_reg == ST_IDLE) && cfg_we && cfg_index == CFG_POOL;
    assign cfg_pool = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;

    assign fits  = !rd_used && rd_len >= bytes_reg;
    assign rem_w = rd_len - bytes_reg;
    assign stop  = (policy_reg == POL_ASC) ? (rd_len >= ins_len_reg)
                                           : (rd_len <= ins_len_reg);
    assign merge_ok = !prev_used_reg && !rd_used &&
                      (LW'(prev_start_reg) + prev_len_reg == LW'(rd_start));
    assign split_start = c_start_reg + bytes_reg[OB-1:0];
    assign x_slot  = phase_reg ? s_slot_reg : c_slot_reg;
    assign x_start = phase_reg ? split_start : c_start_reg;
    assign x_len   = phase_reg ? rem_reg : bytes_reg;

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = cur_reg;
        wr_en     = 1'b0;
        wr_addr   = cur_reg;
        wr_start  = rd_start;
        wr_len    = rd_len;
        wr_used   = rd_used;
        wr_link   = rd_link;
        slot_take = 1'b0;
        slot_push = 1'b0;
        case (state_reg)
            ST_A_RD, ST_I_RD, ST_R_RD:
            begin
                rd_en = i_reg != count_reg;
            end
            ST_A_EV:
            begin
                if (fits && rem_w == '0)
                begin
                    wr_en   = 1'b1;
                    wr_used = 1'b1;
                end
                slot_take = fits && rem_w != '0 && count_reg != COUNT_FULL;
            end
            ST_A_SLOT:
            begin
                if (policy_reg == POL_ADDR)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = c_slot_reg;
                    wr_start = c_start_reg;
                    wr_len   = bytes_reg;
                    wr_used  = 1'b1;
                    wr_link  = slot;
                end
                else
                begin
                    // Unlink the chosen chunk before it is re-inserted by size.
                    wr_en    = prev_v_reg;
                    wr_addr  = prev_slot_reg;
                    wr_start = prev_start_reg;
                    wr_len   = prev_len_reg;
                    wr_used  = prev_used_reg;
                    wr_link  = c_link_reg;
                end
            end
            ST_A_WRS:
            begin
                wr_en    = 1'b1;
                wr_addr  = s_slot_reg;
                wr_start = split_start;
                wr_len   = rem_reg;
                wr_used  = 1'b0;
                wr_link  = c_link_reg;
            end
            ST_I_INS:
            begin
                wr_en    = 1'b1;
                wr_addr  = x_slot;
                wr_start = x_start;
                wr_len   = x_len;
                wr_used  = !phase_reg;
                wr_link  = cur_reg;
            end
            ST_I_LNK:
            begin
                wr_en    = 1'b1;
                wr_addr  = prev_slot_reg;
                wr_start = prev_start_reg;
                wr_len   = prev_len_reg;
                wr_used  = prev_used_reg;
                wr_link  = x_slot;
            end
            ST_R_EV:
            begin
                wr_en   = rd_start == off_reg;
                wr_used = 1'b0;
            end
            ST_M_BEGIN:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            ST_M_Q:
            begin
                rd_en   = (i_reg + CW'(1)) < count_reg;
                rd_addr = prev_link_reg;
            end
            ST_M_QEV, ST_M_END:
            begin
                slot_push = (state_reg == ST_M_QEV) && merge_ok;
                wr_en     = dirty_reg && !((state_reg == ST_M_QEV) && merge_ok);
                wr_addr   = prev_slot_reg;
                wr_start  = prev_start_reg;
                wr_len    = prev_len_reg;
                wr_used   = prev_used_reg;
                wr_link   = prev_link_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            res_ok_reg  <= 1'b0;
            res_off_reg <= '0;
            policy_reg  <= POL_ADDR;
            pool_reg    <= POOL_MAX;
            free_reg    <= POOL_MAX;
            head_reg    <= '0;
            count_reg   <= CW'(1);
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_we)
                    begin
                        case (cfg_index)
                            CFG_ORDER:
                            begin
                                policy_reg <= (cfg_data[1:0] == POL_DESC_ALT) ? POL_DESC
                                                                             : cfg_data[1:0];
                            end
                            default:
                            begin
                                pool_reg  <= cfg_pool;
                                free_reg  <= cfg_pool;
                                head_reg  <= '0;
                                count_reg <= CW'(1);
                            end
                        endcase
                    end
                    if (start)
                    begin
                        bytes_reg  <= request_bytes;
                        off_reg    <= release_offset;
                        cur_reg    <= head_reg;
                        i_reg      <= '0;
                        prev_v_reg <= 1'b0;
                        if (op == OP_RELEASE)
                        begin
                            state_reg <= ST_R_RD;
                        end
                        else if (request_bytes == '0)
                        begin
                            done_reg    <= 1'b1;
                            res_ok_reg  <= 1'b0;
                            res_off_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_A_RD;
                        end
                    end
                end
                ST_A_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        done_reg    <= 1'b1;
                        res_ok_reg  <= 1'b0;
                        res_off_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_A_EV;
                    end
                end
                ST_A_EV:
                begin
                    if (fits)
                    begin
                        c_slot_reg  <= cur_reg;
                        c_start_reg <= rd_start;
                        c_link_reg  <= rd_link;
                        rem_reg     <= rem_w;
                        if (rem_w == '0)
                        begin
                            free_reg    <= free_reg - bytes_reg;
                            done_reg    <= 1'b1;
                            res_ok_reg  <= 1'b1;
                            res_off_reg <= rd_start;
                            state_reg   <= ST_IDLE;
                        end
                        else if (count_reg == COUNT_FULL)
                        begin
                            done_reg    <= 1'b1;
                            res_ok_reg  <= 1'b0;
                            res_off_reg <= '0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_A_SLOT;
                        end
                    end
                    else
                    begin
                        prev_v_reg     <= 1'b1;
                        prev_slot_reg  <= cur_reg;
                        prev_start_reg <= rd_start;
                        prev_len_reg   <= rd_len;
                        prev_used_reg  <= rd_used;
                        prev_link_reg  <= rd_link;
                        cur_reg        <= rd_link;
                        i_reg          <= i_reg + CW'(1);
                        state_reg      <= ST_A_RD;
                    end
                end
                ST_A_SLOT:
                begin
                    s_slot_reg <= slot;
                    if (policy_reg == POL_ADDR)
                    begin
                        state_reg <= ST_A_WRS;
                    end
                    else
                    begin
                        if (!prev_v_reg)
                        begin
                            head_reg <= c_link_reg;
                        end
                        count_reg   <= count_reg - CW'(1);
                        phase_reg   <= 1'b0;
                        ins_len_reg <= bytes_reg;
                        state_reg   <= ST_I_BEGIN;
                    end
                end
                ST_A_WRS:
                begin
                    count_reg   <= count_reg + CW'(1);
                    free_reg    <= free_reg - bytes_reg;
                    done_reg    <= 1'b1;
                    res_ok_reg  <= 1'b1;
                    res_off_reg <= c_start_reg;
                    state_reg   <= ST_IDLE;
                end
                ST_I_BEGIN:
                begin
                    cur_reg    <= head_reg;
                    i_reg      <= '0;
                    prev_v_reg <= 1'b0;
                    state_reg  <= ST_I_RD;
                end
                ST_I_RD:
                begin
                    state_reg <= (i_reg == count_reg) ? ST_I_INS : ST_I_EV;
                end
                ST_I_EV:
                begin
                    if (stop)
                    begin
                        state_reg <= ST_I_INS;
                    end
                    else
                    begin
                        prev_v_reg     <= 1'b1;
                        prev_slot_reg  <= cur_reg;
                        prev_start_reg <= rd_start;
                        prev_len_reg   <= rd_len;
                        prev_used_reg  <= rd_used;
                        prev_link_reg  <= rd_link;
                        cur_reg        <= rd_link;
                        i_reg          <= i_reg + CW'(1);
                        state_reg      <= ST_I_RD;
                    end
                end
                ST_I_INS, ST_I_LNK:
                begin
                    if (state_reg == ST_I_INS)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (state_reg == ST_I_INS && prev_v_reg)
                    begin
                        state_reg <= ST_I_LNK;
                    end
                    else
                    begin
                        if (state_reg == ST_I_INS)
                        begin
                            head_reg <= x_slot;
                        end
                        // The used chunk goes in first, then the remainder.
                        if (!phase_reg)
                        begin
                            phase_reg   <= 1'b1;
                            ins_len_reg <= rem_reg;
                            state_reg   <= ST_I_BEGIN;
                        end
                        else
                        begin
                            free_reg    <= free_reg - bytes_reg;
                            done_reg    <= 1'b1;
                            res_ok_reg  <= 1'b1;
                            res_off_reg <= c_start_reg;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                ST_R_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        done_reg    <= 1'b1;
                        res_ok_reg  <= 1'b0;
                        res_off_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_R_EV;
                    end
                end
                ST_R_EV:
                begin
                    if (rd_start == off_reg)
                    begin
                        if (rd_used)
                        begin
                            free_reg <= free_reg + rd_len;
                        end
                        if (policy_reg == POL_ADDR)
                        begin
                            state_reg <= ST_M_BEGIN;
                        end
                        else
                        begin
                            done_reg    <= 1'b1;
                            res_ok_reg  <= 1'b1;
                            res_off_reg <= '0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        cur_reg   <= rd_link;
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_R_RD;
                    end
                end
                ST_M_BEGIN:
                begin
                    prev_slot_reg <= head_reg;
                    i_reg         <= '0;
                    state_reg     <= ST_M_P;
                end
                ST_M_P:
                begin
                    prev_start_reg <= rd_start;
                    prev_len_reg   <= rd_len;
                    prev_used_reg  <= rd_used;
                    prev_link_reg  <= rd_link;
                    dirty_reg      <= 1'b0;
                    state_reg      <= ST_M_Q;
                end
                ST_M_Q:
                begin
                    state_reg <= ((i_reg + CW'(1)) < count_reg) ? ST_M_QEV : ST_M_END;
                end
                ST_M_QEV:
                begin
                    if (merge_ok)
                    begin
                        // Absorb the follower and stay on the same chunk.
                        prev_len_reg  <= prev_len_reg + rd_len;
                        prev_link_reg <= rd_link;
                        count_reg     <= count_reg - CW'(1);
                        dirty_reg     <= 1'b1;
                    end
                    else
                    begin
                        prev_slot_reg  <= prev_link_reg;
                        prev_start_reg <= rd_start;
                        prev_len_reg   <= rd_len;
                        prev_used_reg  <= rd_used;
                        prev_link_reg  <= rd_link;
                        dirty_reg      <= 1'b0;
                        i_reg          <= i_reg + CW'(1);
                    end
                    state_reg <= ST_M_Q;
                end
                ST_M_END:
                begin
                    done_reg    <= 1'b1;
                    res_ok_reg  <= 1'b1;
                    res_off_reg <= '0;
                    state_reg   <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    cla_ram #(
        .IW(IW),
        .OB(OB)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (ram_init),
        .init_len (pool_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_len   (rd_len),
        .rd_used  (rd_used),
        .rd_link  (rd_link),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_start (wr_start),
        .wr_len   (wr_len),
        .wr_used  (wr_used),
        .wr_link  (wr_link)
    );

    cla_slots #(
        .DEPTH(1 << IW),
        .IW(IW),
        .CW(CW)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (ram_init),
        .push      (slot_push),
        .push_slot (prev_link_reg),
        .take      (slot_take),
        .slot      (slot)
    );

    assign busy           = state_reg != ST_IDLE;
    assign done           = done_reg;
    assign success        = res_ok_reg;
    assign granted_offset = res_off_reg;
    assign free_total     = free_reg;

    // The chunk count dips to zero while a lone chunk is re-inserted by size.
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_count_range, clk, rst_n, state_reg == ST_IDLE,
        count_reg != '0 && count_reg <= COUNT_FULL)
    `ASSERT_IMPL(a_free_bound, clk, rst_n, 1'b1, free_reg <= pool_reg)
    `ASSERT_NEXT(a_start_moves, clk, rst_n, start && !busy, busy || done_reg)
    `ASSERT_IMPL(a_grant_ok, clk, rst_n, done_reg && !res_ok_reg, res_off_reg == '0)

endmodule
